>>> src/gwt_pkg.sv
// Package for the G-code word tokenizer: parse modes, result kinds, character codes,
// the word snapshot that passes from the parser to the scaling stage, and helper functions.
// Depends on nothing.
package gwt_pkg;

  // Width of the signed value range that magnitudes saturate against.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ACC_W   = VALUE_W;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned POW_W   = 20;
  localparam int unsigned CFG_W   = 3;

  // Magnitude limit: two to the power VALUE_W - 1.
  localparam logic [ACC_W-1:0] MAG_LIM = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] FRAC_MAX   = 3'd6;
  localparam logic [CFG_W-1:0] FRAC_RESET = 3'd3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_Z      = 8'h5a;

  typedef enum logic [2:0] {
    MODE_CMD     = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_SKIP    = 3'd2,
    MODE_N       = 3'd3,
    MODE_G       = 3'd4,
    MODE_X       = 3'd5,
    MODE_Y       = 3'd6,
    MODE_Z       = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LINE   = 3'd1,
    KIND_RAPID  = 3'd2,
    KIND_LINEAR = 3'd3,
    KIND_GOTHER = 3'd4,
    KIND_X      = 3'd5,
    KIND_Y      = 3'd6,
    KIND_Z      = 3'd7
  } kind_e;

  // Snapshot of a finished word. A result with no word carries MODE_CMD, zeros and at_end set.
  typedef struct packed {
    mode_e            mode;
    logic [ACC_W-1:0] acc;
    logic             neg;
    logic [2:0]       fc;
    logic             clamp;
    logic             at_end;
  } word_t;

  function automatic logic [CFG_W-1:0] eff_frac(input logic [CFG_W-1:0] frac);
    eff_frac = (frac > FRAC_MAX) ? FRAC_MAX : frac;
  endfunction

  function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
    case (k)
      3'd0:    pow10 = 20'd1;
      3'd1:    pow10 = 20'd10;
      3'd2:    pow10 = 20'd100;
      3'd3:    pow10 = 20'd1000;
      3'd4:    pow10 = 20'd10000;
      3'd5:    pow10 = 20'd100000;
      3'd6:    pow10 = 20'd1000000;
      default: pow10 = 20'd1000000;
    endcase
  endfunction

endpackage

>>> src/gcode_word_tokenizer.sv
// G-code word tokenizer: one text byte per transfer in, one word result per finished word.
// A finished word passes through the word register, then the output register. Throughput:
// one byte per cycle while the output is not stalled; the two result registers keep that
// rate. Reset (rst_ni low, asynchronous) puts the parser in command mode, empties both
// result registers and sets frac_digits to 3. Depends on gwt_pkg, gwt_parse and gwt_scale.
module gcode_word_tokenizer
  import gwt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  // Configuration port. Register 0 at byte address 0 is frac_digits.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  // Byte input channel.
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       text_byte_i,
  input  logic             is_last_i,

  // Result output channel.
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       word_kind_o,
  output logic [OUT_W-1:0] word_value_o,
  output logic             saturated_o,
  output logic             at_end_o
);

  localparam logic REG_FRAC = 1'b0;

  logic [CFG_W-1:0] frac_q;
  logic             cfg_wr;
  logic             accept;
  logic             word_vld;
  logic             word_take;
  word_t            word;

  // The configuration register is written on the access phase of an APB write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_RESET;
    end else if (cfg_wr && paddr[2] == REG_FRAC) begin
      frac_q <= pwdata[CFG_W-1:0];
    end
  end

  // Reads return the register at its address and zero elsewhere; paddr[1:0] is the byte lane.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAC && paddr[1:0] == 2'b00) begin
      prdata = {{(32-CFG_W){1'b0}}, frac_q};
    end
  end

  // A byte may always be taken unless it could produce a word while the word register is
  // still full and cannot move on. Bytes that produce no word are stalled in that case too,
  // which keeps the stall a function of registers and the downstream stall alone.
  assign in_stall_o = word_vld && !word_take;
  assign accept     = in_valid_i && !in_stall_o;

  gwt_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .is_last_i   (is_last_i),
    .frac_i      (frac_q),
    .word_take_i (word_take),
    .word_vld_o  (word_vld),
    .word_o      (word)
  );

  // The scaling stage pads coordinate fractions to frac_digits places, at most six,
  // with one multiply by a power of ten, then clamps, applies the sign and classes the word.
  gwt_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_vld_i   (word_vld),
    .word_i       (word),
    .frac_i       (frac_q),
    .word_take_o  (word_take),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .word_kind_o  (word_kind_o),
    .word_value_o (word_value_o),
    .saturated_o  (saturated_o),
    .at_end_o     (at_end_o)
  );

endmodule

>>> src/gwt_parse.sv
// Byte parser of the G-code word tokenizer: mode and number state registers, and the
// word register that holds a finished word until the scaling stage takes it.
// Depends on gwt_pkg.
module gwt_parse
  import gwt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       text_byte_i,
  input  logic             is_last_i,
  input  logic [CFG_W-1:0] frac_i,
  input  logic             word_take_i,
  output logic             word_vld_o,
  output word_t            word_o
);

  mode_e            mode_q, mode_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic             infrac_q, infrac_d;
  logic [2:0]       fc_q, fc_d;
  logic             started_q, started_d;
  logic             clamp_q, clamp_d;
  logic             word_vld_q;
  word_t            word_q, snap;
  logic             emit;

  logic             is_digit, is_space;
  logic [ACC_W+3:0] push_sum;
  logic [ACC_W-1:0] push_acc;
  logic             push_clamp;

  assign is_digit = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign is_space = (text_byte_i == CH_SPACE) || (text_byte_i == CH_TAB) ||
                    (text_byte_i == CH_LF) || (text_byte_i == CH_VT) ||
                    (text_byte_i == CH_FF) || (text_byte_i == CH_CR);

  // Accumulator times ten plus the digit, clamped to the magnitude limit.
  always_comb begin
    push_sum = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
               {{ACC_W{1'b0}}, text_byte_i[3:0]};
    if (push_sum > {4'b0, MAG_LIM}) begin
      push_acc   = MAG_LIM;
      push_clamp = 1'b1;
    end else begin
      push_acc   = push_sum[ACC_W-1:0];
      push_clamp = clamp_q;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    infrac_d  = infrac_q;
    fc_d      = fc_q;
    started_d = started_q;
    clamp_d   = clamp_q;
    emit      = 1'b0;
    snap      = '{mode: MODE_CMD, acc: '0, neg: 1'b0, fc: 3'd0, clamp: 1'b0,
                  at_end: 1'b1};

    case (mode_q)
      MODE_CMD: begin
        if (text_byte_i == CH_LPAREN) begin
          mode_d = MODE_COMMENT;
        end else if (text_byte_i == CH_PCT || text_byte_i == CH_SPACE ||
                     text_byte_i == CH_LF) begin
          mode_d = MODE_CMD;
        end else if (text_byte_i == CH_N || text_byte_i == CH_G ||
                     text_byte_i == CH_X || text_byte_i == CH_Y ||
                     text_byte_i == CH_Z) begin
          acc_d     = '0;
          neg_d     = 1'b0;
          infrac_d  = 1'b0;
          fc_d      = 3'd0;
          started_d = 1'b0;
          clamp_d   = 1'b0;
          if (text_byte_i == CH_N) begin
            mode_d = MODE_N;
          end else if (text_byte_i == CH_G) begin
            mode_d = MODE_G;
          end else if (text_byte_i == CH_X) begin
            mode_d = MODE_X;
          end else if (text_byte_i == CH_Y) begin
            mode_d = MODE_Y;
          end else begin
            mode_d = MODE_Z;
          end
        end else begin
          mode_d = MODE_SKIP;
        end
      end
      MODE_COMMENT: begin
        if (text_byte_i == CH_RPAREN) begin
          mode_d = MODE_CMD;
        end
      end
      MODE_SKIP: begin
        if (text_byte_i == CH_SPACE || text_byte_i == CH_LF) begin
          mode_d = MODE_CMD;
        end
      end
      default: begin
        if (!started_q && is_space) begin
          mode_d = mode_q;
        end else if (!started_q && (text_byte_i == CH_PLUS ||
                                    text_byte_i == CH_MINUS)) begin
          started_d = 1'b1;
          neg_d     = (text_byte_i == CH_MINUS);
        end else if (is_digit) begin
          started_d = 1'b1;
          if (!infrac_q) begin
            acc_d   = push_acc;
            clamp_d = push_clamp;
          end else if (fc_q < eff_frac(frac_i)) begin
            acc_d   = push_acc;
            clamp_d = push_clamp;
            fc_d    = fc_q + 3'd1;
          end
        end else if (text_byte_i == CH_DOT && mode_q >= MODE_X && !infrac_q) begin
          infrac_d  = 1'b1;
          started_d = 1'b1;
        end else begin
          // Any other byte ends the word; it is consumed.
          emit = 1'b1;
          snap = '{mode: mode_q, acc: acc_q, neg: neg_q, fc: fc_q,
                   clamp: clamp_q, at_end: is_last_i};
          mode_d    = MODE_CMD;
          acc_d     = '0;
          neg_d     = 1'b0;
          infrac_d  = 1'b0;
          fc_d      = 3'd0;
          started_d = 1'b0;
          clamp_d   = 1'b0;
        end
      end
    endcase

    // The final byte of a string always yields a result and returns to command mode.
    if (is_last_i) begin
      if (!emit) begin
        emit = 1'b1;
        if (mode_d >= MODE_N && started_d) begin
          snap = '{mode: mode_d, acc: acc_d, neg: neg_d, fc: fc_d,
                   clamp: clamp_d, at_end: 1'b1};
        end
      end
      mode_d    = MODE_CMD;
      acc_d     = '0;
      neg_d     = 1'b0;
      infrac_d  = 1'b0;
      fc_d      = 3'd0;
      started_d = 1'b0;
      clamp_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CMD;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      infrac_q  <= 1'b0;
      fc_q      <= 3'd0;
      started_q <= 1'b0;
      clamp_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      infrac_q  <= infrac_d;
      fc_q      <= fc_d;
      started_q <= started_d;
      clamp_q   <= clamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= 1'b0;
    end else if (accept_i && emit) begin
      word_vld_q <= 1'b1;
    end else if (word_take_i) begin
      word_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit) begin
      word_q <= snap;
    end
  end

  assign word_vld_o = word_vld_q;
  assign word_o     = word_q;

endmodule

>>> src/gwt_scale.sv
// Scaling stage of the G-code word tokenizer: pads coordinate fractions by one multiply,
// clamps, signs and classes the word, and holds the result in the output register.
// Depends on gwt_pkg.
module gwt_scale
  import gwt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_vld_i,
  input  word_t            word_i,
  input  logic [CFG_W-1:0] frac_i,
  output logic             word_take_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [2:0]       word_kind_o,
  output logic [OUT_W-1:0] word_value_o,
  output logic             saturated_o,
  output logic             at_end_o
);

  localparam int unsigned PROD_W = ACC_W + POW_W;

  logic [CFG_W-1:0]  fd;
  logic [2:0]        pad;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  mag;
  logic              clamp;
  logic [63:0]       val;
  kind_e             kind;

  logic              out_vld_q;
  kind_e             kind_q;
  logic [OUT_W-1:0]  value_q;
  logic              sat_q;
  logic              end_q;

  always_comb begin
    fd    = eff_frac(frac_i);
    pad   = 3'd0;
    if (word_i.mode >= MODE_X && word_i.fc < fd) begin
      pad = fd - word_i.fc;
    end
    // Padding by k zero digits saturates when the scaled value passes the limit, or reaches it for a positive word.
    prod  = PROD_W'(word_i.acc) * PROD_W'(pow10(pad));
    clamp = word_i.clamp;
    if (prod > PROD_W'(MAG_LIM)) begin
      mag   = MAG_LIM;
      clamp = 1'b1;
    end else begin
      mag = prod[ACC_W-1:0];
    end
    if (!word_i.neg && mag == MAG_LIM) begin
      mag   = MAG_LIM - ACC_W'(1);
      clamp = 1'b1;
    end
    val = word_i.neg ? (64'd0 - 64'(mag)) : 64'(mag);

    case (word_i.mode)
      MODE_N: kind = KIND_LINE;
      MODE_G: begin
        if (mag == '0) begin
          kind = KIND_RAPID;
        end else if (mag == ACC_W'(1) && !word_i.neg) begin
          kind = KIND_LINEAR;
        end else begin
          kind = KIND_GOTHER;
        end
      end
      MODE_X:  kind = KIND_X;
      MODE_Y:  kind = KIND_Y;
      MODE_Z:  kind = KIND_Z;
      default: kind = KIND_NONE;
    endcase
  end

  assign word_take_o = word_vld_i && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (word_take_o) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_take_o) begin
      kind_q  <= kind;
      value_q <= val[OUT_W-1:0];
      sat_q   <= clamp;
      end_q   <= word_i.at_end;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign word_kind_o  = kind_q;
  assign word_value_o = value_q;
  assign saturated_o  = sat_q;
  assign at_end_o     = end_q;

endmodule
